/* rtl/core/ahsd_pkg.sv */
// Package for the ASCII hex stream decoder: mode, opcode and status codes,
// character constants, the hex digit decoding function and the separator test. No dependencies.
`default_nettype none

package ahsd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_RECEIVING = 2'd1,
        MODE_DONE      = 2'd2,
        MODE_ERROR     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_START  = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_REFUSED  = 2'd1,
        STATUS_BAD_CHAR = 2'd2
    } t_status;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_digit;

    function automatic t_digit decode_digit(input logic [7:0] ch);
        t_digit d;
        logic [7:0] diff;
        d.is_hex = 1'b0;
        d.value  = 4'd0;
        diff     = 8'd0;
        if (ch >= CHAR_0 && ch <= CHAR_9) begin
            diff     = ch - CHAR_0;
            d.is_hex = 1'b1;
        end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
            diff     = ch - CHAR_UP_A + DIGIT_TEN;
            d.is_hex = 1'b1;
        end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
            diff     = ch - CHAR_LO_A + DIGIT_TEN;
            d.is_hex = 1'b1;
        end
        d.value = diff[3:0];
        return d;
    endfunction

    function automatic logic is_separator(input logic [7:0] ch);
        return (ch == CHAR_CR) || (ch == CHAR_LF) || (ch == CHAR_SPACE) || (ch == CHAR_TAB);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ascii_hex_stream_decoder.sv */
// An accepted word is held in the input register, then decoded into the output register.
// Throughput: one word per cycle; the input register advances whenever the output
// register is empty or being taken, so the slave side stalls only with the master side.
// Reset (synchronous, active low) empties both registers, returns to idle with a
// cleared digit pair and byte count, and sets the expected size to zero.
// Depends on ahsd_pkg.
`default_nettype none

module ascii_hex_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // char_code
    input  wire logic [1:0]  s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // byte_value [7:0], bytes_written [39:8]
    output logic [5:0]       m_axis_tuser   // byte_valid, status [2:1], run_mode [4:3], complete
);
    import ahsd_pkg::*;

    logic        r_in_valid;
    t_opcode     r_in_op;
    logic [7:0]  r_in_char;

    logic [31:0] r_expected;
    t_mode       r_mode;
    logic        r_have_high;
    logic [3:0]  r_high;
    logic [31:0] r_count;

    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic [5:0]  r_out_user;

    t_mode       n_mode;
    logic        n_have_high;
    logic [3:0]  n_high;
    logic [31:0] n_count;
    logic        n_byte_valid;
    logic [7:0]  n_byte_value;
    t_status     n_status;

    logic        advance;
    t_digit      digit;
    logic [31:0] count_inc;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    assign digit     = decode_digit(r_in_char);
    assign count_inc = r_count + 32'd1;

    always_comb begin
        n_mode       = r_mode;
        n_have_high  = r_have_high;
        n_high       = r_high;
        n_count      = r_count;
        n_byte_valid = 1'b0;
        n_byte_value = 8'd0;
        n_status     = STATUS_OK;
        unique case (r_in_op)
            OP_START: begin
                n_mode      = MODE_RECEIVING;
                n_have_high = 1'b0;
                n_high      = 4'd0;
                n_count     = 32'd0;
            end
            OP_CLOSE: begin
                if (r_mode != MODE_ERROR) begin
                    n_mode = MODE_IDLE;
                end
            end
            OP_CHAR: begin
                priority if (r_mode != MODE_RECEIVING) begin
                    n_status = STATUS_REFUSED;
                end else if (is_separator(r_in_char)) begin
                    n_status = STATUS_OK;
                end else if (!digit.is_hex) begin
                    n_mode   = MODE_ERROR;
                    n_status = STATUS_BAD_CHAR;
                end else if (!r_have_high) begin
                    n_high      = digit.value;
                    n_have_high = 1'b1;
                end else begin
                    n_byte_valid = 1'b1;
                    n_byte_value = {r_high, digit.value};
                    n_count      = count_inc;
                    n_have_high  = 1'b0;
                    if (count_inc >= r_expected) begin
                        n_mode = MODE_DONE;
                    end
                end
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_expected  <= 32'd0;
            r_mode      <= MODE_IDLE;
            r_have_high <= 1'b0;
            r_high      <= 4'd0;
            r_count     <= 32'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_expected <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_mode      <= n_mode;
                r_have_high <= n_have_high;
                r_high      <= n_high;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= t_opcode'(s_axis_tuser);
            r_in_char <= s_axis_tdata;
        end
        if (advance) begin
            r_out_data <= {n_count, n_byte_value};
            r_out_user <= {n_mode == MODE_DONE, n_mode, n_status, n_byte_valid};
        end
    end

`ifndef ASSERT_OFF
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_op == OP_START |=> r_count == 32'd0 && !r_have_high
            && r_mode == MODE_RECEIVING)
        else $error("Start did not clear the pair and count.");

    a_byte_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_byte_valid |=> r_count == $past(r_count) + 32'd1)
        else $error("Decoded byte did not advance the count by one.");

    a_refused_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_op == OP_CHAR && r_mode != MODE_RECEIVING
        |=> $stable(r_mode) && $stable(r_count) && $stable(r_have_high))
        else $error("Refused character changed the state.");

    a_byte_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user[0] |-> r_out_user[2:1] == STATUS_OK
            && (r_out_user[4:3] == MODE_RECEIVING || r_out_user[4:3] == MODE_DONE))
        else $error("Decoded byte carries a wrong status or mode.");
`endif

endmodule

`default_nettype wire

/* tb/ascii_hex_stream_decoder_test.sv */
// Self-checking testbench for ascii_hex_stream_decoder: directed and random hex uploads
// on the stream ports, with a scoreboard that tracks the decoder state and checks each word.
// Depends on ahsd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module ascii_hex_stream_decoder_test;
    import ahsd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_CAP  = 40;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  byte_value;
        t_status     status;
        t_mode       run_mode;
        logic        complete;
        logic [31:0] bytes_written;
    } t_decoded_word;

    class hex_byte_scoreboard;
        t_mode         mode;
        logic          have_high;
        logic [3:0]    high_nibble;
        logic [31:0]   byte_count;
        logic [31:0]   size_limit;
        t_decoded_word awaited[$];
        int            errors;

        function new();
            mode        = MODE_IDLE;
            have_high   = 1'b0;
            high_nibble = 4'd0;
            byte_count  = 32'd0;
            size_limit  = 32'd0;
            errors      = 0;
        endfunction

        function void set_size(logic [31:0] value);
            size_limit = value;
        endfunction

        function int pending_count();
            return awaited.size();
        endfunction

        function logic is_blank(logic [7:0] ch);
            return ch == CHAR_CR || ch == CHAR_LF || ch == CHAR_SPACE || ch == CHAR_TAB;
        endfunction

        // Bit 4 set means the character is not a hex digit.
        function logic [4:0] nibble_of(logic [7:0] ch);
            logic [7:0] offset;
            offset = 8'd0;
            if (ch >= CHAR_0 && ch <= CHAR_9) begin
                offset = ch - CHAR_0;
            end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
                offset = ch - CHAR_UP_A + 8'd10;
            end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
                offset = ch - CHAR_LO_A + 8'd10;
            end else begin
                return 5'h10;
            end
            return {1'b0, offset[3:0]};
        endfunction

        function void note_word(t_opcode op, logic [7:0] ch);
            t_decoded_word r;
            logic [4:0]    nib;
            r        = '0;
            r.status = STATUS_OK;
            case (op)
                OP_START: begin
                    byte_count  = 32'd0;
                    have_high   = 1'b0;
                    high_nibble = 4'd0;
                    mode        = MODE_RECEIVING;
                end
                OP_CLOSE: begin
                    if (mode != MODE_ERROR) mode = MODE_IDLE;
                end
                OP_CHAR: begin
                    if (mode != MODE_RECEIVING) begin
                        r.status = STATUS_REFUSED;
                    end else if (!is_blank(ch)) begin
                        nib = nibble_of(ch);
                        if (nib[4]) begin
                            mode     = MODE_ERROR;
                            r.status = STATUS_BAD_CHAR;
                        end else if (!have_high) begin
                            high_nibble = nib[3:0];
                            have_high   = 1'b1;
                        end else begin
                            r.byte_valid = 1'b1;
                            r.byte_value = {high_nibble, nib[3:0]};
                            byte_count   = byte_count + 32'd1;
                            have_high    = 1'b0;
                            if (byte_count >= size_limit) mode = MODE_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
            r.run_mode      = mode;
            r.complete      = (mode == MODE_DONE);
            r.bytes_written = byte_count;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                if (errors < REPORT_CAP)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [39:0] data, logic [5:0] user);
            t_decoded_word want;
            if (awaited.size() == 0) begin
                if (errors < REPORT_CAP)
                    $display("%0t: unexpected word, expected none, actual %h/%h", $time, data, user);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("byte_valid", 32'(want.byte_valid), 32'(user[0]));
            compare_field("status", 32'(want.status), 32'(user[2:1]));
            compare_field("run_mode", 32'(want.run_mode), 32'(user[4:3]));
            compare_field("complete", 32'(want.complete), 32'(user[5]));
            compare_field("byte_value", 32'(want.byte_value), 32'(data[7:0]));
            compare_field("bytes_written", want.bytes_written, data[39:8]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // char_code
    logic [1:0]  s_axis_tuser = 2'd0;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // byte_value [7:0], bytes_written [39:8]
    logic [5:0]  m_axis_tuser;          // byte_valid, status [2:1], run_mode [4:3], complete

    hex_byte_scoreboard sb;
    int send_idle_pct = 18;
    int recv_idle_pct = 83;
    int hold_request  = 0;
    int hold_left     = 0;
    int words_sent    = 0;
    int cycles        = 0;

    logic [31:0] size_plan [6] = '{32'hFFFF_FFFF, 32'd3, 32'd0, 32'd5, 32'd1, 32'd2};

    ascii_hex_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver either serves a long hold-off or stalls at the current rate.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left     <= hold_request - 1;
            hold_request  <= 0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_word(t_opcode op, logic [7:0] ch);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, ch);
        words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_size(logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_size(value);
    endtask

    function automatic logic [7:0] pick_digit();
        int d;
        d = $urandom_range(15);
        if (d < 10) return CHAR_0 + 8'(d);
        return ($urandom_range(1) ? CHAR_UP_A : CHAR_LO_A) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return CHAR_CR;
            1: return CHAR_LF;
            2: return CHAR_SPACE;
            default: return CHAR_TAB;
        endcase
    endfunction

    task automatic send_digit_or_blank();
        if ($urandom_range(99) < 20) send_word(OP_CHAR, pick_blank());
        send_word(OP_CHAR, pick_digit());
    endtask

    task automatic random_upload();
        int n_bytes;
        int bad_at;
        n_bytes = $urandom_range(6);
        bad_at  = ($urandom_range(99) < 15) ? $urandom_range(2 * n_bytes) : -1;
        send_word(OP_START, 8'($urandom));
        for (int k = 0; k < 2 * n_bytes; k++) begin
            if (k == bad_at) send_word(OP_CHAR, 8'($urandom));
            send_digit_or_blank();
        end
        if ($urandom_range(99) < 15) send_word(OP_CHAR, pick_digit());
        if ($urandom_range(99) < 35) send_word(OP_CLOSE, 8'($urandom));
    endtask

    initial begin
        int target;
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_CHAR, CHAR_UP_A);
        send_word(OP_UNUSED, 8'hFF);
        send_word(OP_CLOSE, 8'h00);
        send_word(OP_START, 8'h00);
        send_word(OP_CHAR, CHAR_CR);
        send_word(OP_CHAR, CHAR_0);
        send_word(OP_CHAR, CHAR_LF);
        send_word(OP_CHAR, CHAR_SPACE);
        send_word(OP_CHAR, CHAR_TAB);
        send_word(OP_CHAR, CHAR_9);
        send_word(OP_CHAR, CHAR_LO_F);
        send_word(OP_CLOSE, 8'h55);
        send_word(OP_START, 8'hAA);
        send_word(OP_CHAR, CHAR_UP_A);
        send_word(OP_CHAR, CHAR_LO_F);
        send_word(OP_START, 8'h00);
        send_word(OP_CHAR, CHAR_UP_F);
        send_word(OP_CHAR, CHAR_LO_A);
        send_word(OP_START, 8'h00);
        send_word(OP_CHAR, 8'h67);
        send_word(OP_CLOSE, 8'h00);
        send_word(OP_CHAR, 8'hFF);
        send_word(OP_START, 8'h00);
        send_word(OP_CHAR, CHAR_LO_A);
        send_word(OP_CHAR, 8'h00);

        for (int seg = 0; seg < 6; seg++) begin
            wait_drained();
            send_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 83 : 0;
            recv_idle_pct = (seg < 2) ? 83 : (seg < 4) ? 18 : 0;
            write_size(size_plan[seg]);
            if (seg == 4) hold_request = 60;
            target = words_sent + 90;
            while (words_sent < target) begin
                if ($urandom_range(9) == 0)
                    send_word(t_opcode'($urandom_range(3)), 8'($urandom));
                else
                    random_upload();
            end
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ahsd_pkg.sv
rtl/core/ascii_hex_stream_decoder.sv
tb/ascii_hex_stream_decoder_test.sv
